// File: rtl/wavhdr_pkg.sv
// Shared types and constants for the RIFF/WAVE header parser.
// Depends on nothing; used by wavhdr_parser and wav_header_chunk_parser.
package wavhdr_pkg;

  // Chunk tags, first file byte in the most significant position.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
  localparam logic [15:0] BITS_8       = 16'd8;
  localparam logic [15:0] BITS_16      = 16'd16;
  localparam logic [15:0] CHAN_MONO    = 16'd1;
  localparam logic [15:0] CHAN_STEREO  = 16'd2;
  localparam logic [15:0] AFMT_PCM     = 16'd1;

  // Byte index within a tag or size field, or within the fmt body (saturates at 16).
  localparam int unsigned FS_W = 5;

  typedef enum logic [3:0] {
    PH_RIFF      = 4'd0,
    PH_RIFF_SIZE = 4'd1,
    PH_WAVE      = 4'd2,
    PH_FMT_TAG   = 4'd3,
    PH_FMT_SIZE  = 4'd4,
    PH_FMT_BODY  = 4'd5,
    PH_NAME      = 4'd6,
    PH_SIZE      = 4'd7,
    PH_BODY      = 4'd8,
    PH_STOP      = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    FC_UNSUPPORTED = 3'd0,
    FC_MONO8       = 3'd1,
    FC_STEREO8     = 3'd2,
    FC_MONO16      = 3'd3,
    FC_STEREO16    = 3'd4
  } fmt_code_t;

  typedef struct packed {
    logic        header_ok;
    logic        pcm_format;
    logic [2:0]  format_code;
    logic [31:0] sample_rate;
    logic        data_found;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic        fmt_too_short;
  } summary_t;

endpackage

// File: rtl/wavhdr_parser.sv
// Byte-wise chunk walker for the RIFF/WAVE header parser.
// Depends on wavhdr_pkg; holds the parse state and forms the file summary.
module wavhdr_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_en,
  input  logic [7:0]            file_byte,
  input  logic                  last_byte,
  output wavhdr_pkg::summary_t  summary
);

  logic [31:0]                    pos_r, pos_nxt;
  wavhdr_pkg::phase_t             phase_r, phase_nxt;
  logic [31:0]                    tag_r, tag_nxt;
  logic [wavhdr_pkg::FS_W-1:0]    fs_r, fs_nxt;
  logic [31:0]                    rem_r, rem_nxt;
  logic                           hdr_ok_r, hdr_ok_nxt;
  logic [15:0]                    afmt_r, afmt_nxt;
  logic [15:0]                    chan_r, chan_nxt;
  logic [31:0]                    rate_r, rate_nxt;
  logic [15:0]                    bits_r, bits_nxt;
  logic                           dseen_r, dseen_nxt;
  logic [31:0]                    dstart_r, dstart_nxt;
  logic [31:0]                    dlen_r, dlen_nxt;
  logic                           fshort_r, fshort_nxt;

  logic [31:0]                    tag_shift;
  logic [wavhdr_pkg::FS_W-1:0]    fs_inc;
  logic                           field_done;
  logic [31:0]                    size_acc;
  logic [31:0]                    rem_dec;
  logic [31:0]                    pos_inc;

  assign tag_shift  = {tag_r[23:0], file_byte};
  assign fs_inc     = fs_r + wavhdr_pkg::FS_W'(1);
  assign field_done = (fs_r[1:0] == 2'd3);
  assign rem_dec    = rem_r - 32'd1;
  assign pos_inc    = pos_r + 32'd1;

  always_comb begin
    size_acc = rem_r;
    case (fs_r[1:0])
      2'd0:    size_acc[7:0]   = rem_r[7:0]   | file_byte;
      2'd1:    size_acc[15:8]  = rem_r[15:8]  | file_byte;
      2'd2:    size_acc[23:16] = rem_r[23:16] | file_byte;
      default: size_acc[31:24] = rem_r[31:24] | file_byte;
    endcase
  end

  // Next parse state for one byte.
  always_comb begin
    phase_nxt  = phase_r;
    tag_nxt    = tag_r;
    fs_nxt     = fs_r;
    rem_nxt    = rem_r;
    hdr_ok_nxt = hdr_ok_r;
    afmt_nxt   = afmt_r;
    chan_nxt   = chan_r;
    rate_nxt   = rate_r;
    bits_nxt   = bits_r;
    dseen_nxt  = dseen_r;
    dstart_nxt = dstart_r;
    dlen_nxt   = dlen_r;
    fshort_nxt = fshort_r;
    pos_nxt    = pos_r;

    if (byte_en) begin
      pos_nxt = pos_inc;
      case (phase_r)
        wavhdr_pkg::PH_RIFF, wavhdr_pkg::PH_WAVE, wavhdr_pkg::PH_FMT_TAG: begin
          tag_nxt = tag_shift;
          fs_nxt  = fs_inc;
          if (field_done) begin
            fs_nxt = '0;
            if (phase_r == wavhdr_pkg::PH_RIFF) begin
              phase_nxt = (tag_shift == wavhdr_pkg::TAG_RIFF) ?
                          wavhdr_pkg::PH_RIFF_SIZE : wavhdr_pkg::PH_STOP;
            end else if (phase_r == wavhdr_pkg::PH_WAVE) begin
              phase_nxt = (tag_shift == wavhdr_pkg::TAG_WAVE) ?
                          wavhdr_pkg::PH_FMT_TAG : wavhdr_pkg::PH_STOP;
            end else if (tag_shift == wavhdr_pkg::TAG_FMT) begin
              phase_nxt  = wavhdr_pkg::PH_FMT_SIZE;
              hdr_ok_nxt = 1'b1;
              rem_nxt    = '0;
            end else begin
              phase_nxt = wavhdr_pkg::PH_STOP;
            end
          end
        end
        wavhdr_pkg::PH_RIFF_SIZE: begin
          fs_nxt = fs_inc;
          if (field_done) begin
            fs_nxt    = '0;
            phase_nxt = wavhdr_pkg::PH_WAVE;
          end
        end
        wavhdr_pkg::PH_FMT_SIZE: begin
          rem_nxt = size_acc;
          fs_nxt  = fs_inc;
          if (field_done) begin
            fs_nxt     = '0;
            fshort_nxt = (size_acc < wavhdr_pkg::FMT_MIN_SIZE);
            phase_nxt  = (size_acc != '0) ? wavhdr_pkg::PH_FMT_BODY : wavhdr_pkg::PH_NAME;
          end
        end
        wavhdr_pkg::PH_FMT_BODY: begin
          case (fs_r)
            5'd0:    afmt_nxt[7:0]   = afmt_r[7:0]   | file_byte;
            5'd1:    afmt_nxt[15:8]  = afmt_r[15:8]  | file_byte;
            5'd2:    chan_nxt[7:0]   = chan_r[7:0]   | file_byte;
            5'd3:    chan_nxt[15:8]  = chan_r[15:8]  | file_byte;
            5'd4:    rate_nxt[7:0]   = rate_r[7:0]   | file_byte;
            5'd5:    rate_nxt[15:8]  = rate_r[15:8]  | file_byte;
            5'd6:    rate_nxt[23:16] = rate_r[23:16] | file_byte;
            5'd7:    rate_nxt[31:24] = rate_r[31:24] | file_byte;
            5'd14:   bits_nxt[7:0]   = bits_r[7:0]   | file_byte;
            5'd15:   bits_nxt[15:8]  = bits_r[15:8]  | file_byte;
            default: ;
          endcase
          if (fs_r < wavhdr_pkg::FS_W'(wavhdr_pkg::FMT_MIN_SIZE)) begin
            fs_nxt = fs_inc;
          end
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            fs_nxt    = '0;
            phase_nxt = wavhdr_pkg::PH_NAME;
          end
        end
        wavhdr_pkg::PH_NAME: begin
          tag_nxt = tag_shift;
          fs_nxt  = fs_inc;
          if (field_done) begin
            fs_nxt    = '0;
            rem_nxt   = '0;
            phase_nxt = wavhdr_pkg::PH_SIZE;
          end
        end
        wavhdr_pkg::PH_SIZE: begin
          rem_nxt = size_acc;
          fs_nxt  = fs_inc;
          if (field_done) begin
            fs_nxt = '0;
            if (tag_r == wavhdr_pkg::TAG_DATA) begin
              dseen_nxt  = 1'b1;
              dstart_nxt = pos_inc;
              dlen_nxt   = size_acc;
            end
            phase_nxt = (size_acc != '0) ? wavhdr_pkg::PH_BODY : wavhdr_pkg::PH_NAME;
          end
        end
        wavhdr_pkg::PH_BODY: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = wavhdr_pkg::PH_NAME;
          end
        end
        default: ;
      endcase
    end
  end

  // Summary of the file as it stands after the current byte.
  always_comb begin
    summary = '0;
    if (hdr_ok_nxt) begin
      summary.header_ok     = 1'b1;
      summary.pcm_format    = (afmt_nxt == wavhdr_pkg::AFMT_PCM);
      summary.sample_rate   = rate_nxt;
      summary.data_found    = dseen_nxt;
      summary.data_offset   = dseen_nxt ? dstart_nxt : '0;
      summary.data_size     = dseen_nxt ? dlen_nxt : '0;
      summary.fmt_too_short = fshort_nxt;
      summary.format_code   = wavhdr_pkg::FC_UNSUPPORTED;
      if (bits_nxt == wavhdr_pkg::BITS_8) begin
        if (chan_nxt == wavhdr_pkg::CHAN_MONO) begin
          summary.format_code = wavhdr_pkg::FC_MONO8;
        end else if (chan_nxt == wavhdr_pkg::CHAN_STEREO) begin
          summary.format_code = wavhdr_pkg::FC_STEREO8;
        end
      end else if (bits_nxt == wavhdr_pkg::BITS_16) begin
        if (chan_nxt == wavhdr_pkg::CHAN_MONO) begin
          summary.format_code = wavhdr_pkg::FC_MONO16;
        end else if (chan_nxt == wavhdr_pkg::CHAN_STEREO) begin
          summary.format_code = wavhdr_pkg::FC_STEREO16;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_en && last_byte)) begin
      pos_r    <= '0;
      phase_r  <= wavhdr_pkg::PH_RIFF;
      tag_r    <= '0;
      fs_r     <= '0;
      rem_r    <= '0;
      hdr_ok_r <= 1'b0;
      afmt_r   <= '0;
      chan_r   <= '0;
      rate_r   <= '0;
      bits_r   <= '0;
      dseen_r  <= 1'b0;
      dstart_r <= '0;
      dlen_r   <= '0;
      fshort_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      tag_r    <= tag_nxt;
      fs_r     <= fs_nxt;
      rem_r    <= rem_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      afmt_r   <= afmt_nxt;
      chan_r   <= chan_nxt;
      rate_r   <= rate_nxt;
      bits_r   <= bits_nxt;
      dseen_r  <= dseen_nxt;
      dstart_r <= dstart_nxt;
      dlen_r   <= dlen_nxt;
      fshort_r <= fshort_nxt;
    end
  end

endmodule

// File: rtl/wav_header_chunk_parser.sv
// Top level of the RIFF/WAVE header parser: handshakes and the result register.
// Depends on wavhdr_pkg and wavhdr_parser.
//
// Usage. The input channel carries one file byte per word (in_file_byte) with
// a flag on the final byte of the file (in_last_byte). The parser checks the
// "RIFF", "WAVE" and leading "fmt " tags, captures the fmt fields and walks the
// chunk headers, remembering the offset and size of the last "data" chunk.
// Bytes that are not the last produce no word on the output channel.
// When the last byte is accepted, one summary word is loaded into the output
// register and shown on the out_ ports from the next cycle.
// Throughput is one byte per clock: the parse state and the summary logic sit
// between the byte handshake and the output register, a single pass per byte.
// When the receiver stalls with a summary pending, in_ready drops until that
// word is taken; bytes of a new file flow again in the cycle it leaves.
// After the last byte the parse state returns to its reset values, so the
// next byte starts a new file.
// Reset (rst_n low, synchronous) clears the parse state and empties the
// output register.
module wav_header_chunk_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_header_ok,
  output logic        out_pcm_format,
  output logic [2:0]  out_format_code,
  output logic [31:0] out_sample_rate,
  output logic        out_data_found,
  output logic [31:0] out_data_offset,
  output logic [31:0] out_data_size,
  output logic        out_fmt_too_short
);

  logic                  in_fire;
  logic                  out_valid_r, out_valid_nxt;
  wavhdr_pkg::summary_t  summary;
  wavhdr_pkg::summary_t  res_r;

  // A pending summary blocks new bytes only while the receiver holds it.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  wavhdr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_fire),
    .file_byte (in_file_byte),
    .last_byte (in_last_byte),
    .summary   (summary)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && in_last_byte) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register: loaded only with the summary of a finished file.
  always_ff @(posedge clk) begin
    if (in_fire && in_last_byte) begin
      res_r <= summary;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_header_ok     = res_r.header_ok;
  assign out_pcm_format    = res_r.pcm_format;
  assign out_format_code   = res_r.format_code;
  assign out_sample_rate   = res_r.sample_rate;
  assign out_data_found    = res_r.data_found;
  assign out_data_offset   = res_r.data_offset;
  assign out_data_size     = res_r.data_size;
  assign out_fmt_too_short = res_r.fmt_too_short;

  // A final byte always yields a summary word in the following cycle.
  a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_byte) |=> out_valid)
    else $error("final byte accepted but no summary word followed");

  // A byte that is not the last never creates a summary word.
  a_no_spurious_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !(in_fire && in_last_byte)) |=> !out_valid)
    else $error("summary word appeared without a final byte");

  // A rejected header reports nothing else.
  a_bad_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_header_ok) |-> (!out_pcm_format &&
      out_format_code == wavhdr_pkg::FC_UNSUPPORTED &&
      out_sample_rate == 32'd0 && !out_data_found && !out_fmt_too_short))
    else $error("fields set in a summary with a rejected header");

  // Without a data chunk the data offset and size stay zero.
  a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data_found) |-> (out_data_offset == 32'd0 && out_data_size == 32'd0))
    else $error("data offset or size reported without a data chunk");

endmodule

// File: tb/sv/wav_header_chunk_parser_tb.sv
// Self-checking testbench for wav_header_chunk_parser: byte stream in, file summary out.
// Depends on wavhdr_pkg and the RTL; a behavioural parser predicts the summary of every random file.
module wav_header_chunk_parser_tb;
  import wavhdr_pkg::*;

  // One row of the directed table. Rows that close a file with a known outcome carry
  // want_zero: the summary for those is all zeros and is typed in rather than predicted.
  typedef struct packed {
    logic [7:0] fbyte;
    logic       last;
    logic       want_zero;
  } byte_row_t;

  localparam int unsigned N_ROWS      = 20;
  localparam int unsigned LIMIT_CYCLS = 200000;
  localparam int unsigned PHASE_BYTES = 375;
  localparam int unsigned PHASE_FILES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_file_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_header_ok;
  logic        out_pcm_format;
  logic [2:0]  out_format_code;
  logic [31:0] out_sample_rate;
  logic        out_data_found;
  logic [31:0] out_data_offset;
  logic [31:0] out_data_size;
  logic        out_fmt_too_short;

  wav_header_chunk_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_file_byte      (in_file_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_header_ok     (out_header_ok),
    .out_pcm_format    (out_pcm_format),
    .out_format_code   (out_format_code),
    .out_sample_rate   (out_sample_rate),
    .out_data_found    (out_data_found),
    .out_data_offset   (out_data_offset),
    .out_data_size     (out_data_size),
    .out_fmt_too_short (out_fmt_too_short)
  );

  // Summaries predicted for accepted last bytes, oldest first.
  summary_t    summaries_due[$];
  // The file currently being built by the random generator.
  logic [7:0]  file_q[$];
  byte_row_t   dir_rows[N_ROWS];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned bytes_sent;
  int unsigned files_sent;
  int unsigned summaries_checked;
  int unsigned mismatch_count;

  // ---------------------------------------------------------------------------
  // Behavioural parser. It keeps its own copy of the parse state and is stepped
  // once for every byte the block accepts.
  // ---------------------------------------------------------------------------
  logic [31:0] file_pos;
  phase_t      parse_state;
  logic [31:0] tag_shift;
  int unsigned byte_idx;
  logic [31:0] bytes_left;
  logic        header_matched;
  logic [15:0] audio_fmt;
  logic [15:0] num_chans;
  logic [31:0] rate_field;
  logic [15:0] bits_per_sample;
  logic        data_hit;
  logic [31:0] data_off;
  logic [31:0] data_len;
  logic        fmt_short;

  task automatic clear_parser();
    file_pos        = '0;
    parse_state     = PH_RIFF;
    tag_shift       = '0;
    byte_idx        = 0;
    bytes_left      = '0;
    header_matched  = 1'b0;
    audio_fmt       = '0;
    num_chans       = '0;
    rate_field      = '0;
    bits_per_sample = '0;
    data_hit        = 1'b0;
    data_off        = '0;
    data_len        = '0;
    fmt_short       = 1'b0;
  endtask

  // Shifts a byte into the tag window; after four bytes the tag either matches and
  // the walk moves on, or the parser gives up on the file.
  task automatic match_tag(input logic [7:0] b, input logic [31:0] tag, input phase_t next);
    tag_shift = {tag_shift[23:0], b};
    byte_idx++;
    if (byte_idx >= 4) begin
      byte_idx = 0;
      if (tag_shift == tag) begin
        parse_state = next;
        if (tag == TAG_FMT) header_matched = 1'b1;
      end else begin
        parse_state = PH_STOP;
      end
    end
  endtask

  // Collects one little-endian size byte; true once all four are in.
  function automatic bit take_size_byte(input logic [7:0] b);
    bytes_left = bytes_left | (32'(b) << (8 * (byte_idx & 3)));
    byte_idx++;
    if (byte_idx >= 4) begin
      byte_idx = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output bit emit, output summary_t s);
    logic [31:0] pos;
    pos  = file_pos;
    emit = 1'b0;
    s    = '0;
    case (parse_state)
      PH_RIFF: match_tag(b, TAG_RIFF, PH_RIFF_SIZE);
      PH_RIFF_SIZE: begin
        byte_idx++;
        if (byte_idx >= 4) begin
          byte_idx    = 0;
          parse_state = PH_WAVE;
        end
      end
      PH_WAVE: match_tag(b, TAG_WAVE, PH_FMT_TAG);
      PH_FMT_TAG: begin
        match_tag(b, TAG_FMT, PH_FMT_SIZE);
        if (parse_state == PH_FMT_SIZE) bytes_left = '0;
      end
      PH_FMT_SIZE: begin
        if (take_size_byte(b)) begin
          fmt_short   = bytes_left < FMT_MIN_SIZE;
          parse_state = (bytes_left != 0) ? PH_FMT_BODY : PH_NAME;
        end
      end
      PH_FMT_BODY: begin
        if (byte_idx < 2)
          audio_fmt = audio_fmt | (16'(b) << (8 * byte_idx));
        else if (byte_idx < 4)
          num_chans = num_chans | (16'(b) << (8 * (byte_idx - 2)));
        else if (byte_idx < 8)
          rate_field = rate_field | (32'(b) << (8 * (byte_idx - 4)));
        else if (byte_idx >= 14 && byte_idx < 16)
          bits_per_sample = bits_per_sample | (16'(b) << (8 * (byte_idx - 14)));
        if (byte_idx < 16) byte_idx++;
        bytes_left = bytes_left - 1;
        if (bytes_left == 0) begin
          byte_idx    = 0;
          parse_state = PH_NAME;
        end
      end
      PH_NAME: begin
        tag_shift = {tag_shift[23:0], b};
        byte_idx++;
        if (byte_idx >= 4) begin
          byte_idx    = 0;
          bytes_left  = '0;
          parse_state = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (take_size_byte(b)) begin
          if (tag_shift == TAG_DATA) begin
            data_hit = 1'b1;
            data_off = pos + 1;
            data_len = bytes_left;
          end
          parse_state = (bytes_left != 0) ? PH_BODY : PH_NAME;
        end
      end
      PH_BODY: begin
        bytes_left = bytes_left - 1;
        if (bytes_left == 0) parse_state = PH_NAME;
      end
      default: ;
    endcase
    file_pos = pos + 1;

    if (last) begin
      emit = 1'b1;
      if (header_matched) begin
        s.header_ok   = 1'b1;
        s.pcm_format  = (audio_fmt == AFMT_PCM);
        s.format_code = FC_UNSUPPORTED;
        if (bits_per_sample == BITS_8) begin
          if (num_chans == CHAN_MONO)   s.format_code = FC_MONO8;
          if (num_chans == CHAN_STEREO) s.format_code = FC_STEREO8;
        end else if (bits_per_sample == BITS_16) begin
          if (num_chans == CHAN_MONO)   s.format_code = FC_MONO16;
          if (num_chans == CHAN_STEREO) s.format_code = FC_STEREO16;
        end
        s.sample_rate   = rate_field;
        s.data_found    = data_hit;
        s.data_offset   = data_hit ? data_off : '0;
        s.data_size     = data_hit ? data_len : '0;
        s.fmt_too_short = fmt_short;
      end
      // The block starts afresh after the last byte of a file, and so do we.
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and the fixed time limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A hung handshake would otherwise leave the run going for ever.
  initial begin
    #(12 * LIMIT_CYCLS);
    $display("Run stopped by the time limit with %0d summaries outstanding",
             summaries_due.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver. out_ready is redrawn at every falling edge according to the current
  // stall rate, so stalls land on every phase of the block's work.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Summary %0d, %s: expected 0x%0h, got 0x%0h",
                 summaries_checked, field, want, got);
    end
  endtask

  // Every accepted summary word is held against the oldest prediction, field by field.
  always @(posedge clk) begin
    summary_t want;
    if (rst_n && out_valid && out_ready) begin
      if (summaries_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Summary word arrived with none expected (header_ok %0b, offset 0x%0h)",
                   out_header_ok, out_data_offset);
      end else begin
        want = summaries_due.pop_front();
        report_field("header_ok",     32'(want.header_ok),     32'(out_header_ok));
        report_field("pcm_format",    32'(want.pcm_format),    32'(out_pcm_format));
        report_field("format_code",   32'(want.format_code),   32'(out_format_code));
        report_field("sample_rate",   want.sample_rate,        out_sample_rate);
        report_field("data_found",    32'(want.data_found),    32'(out_data_found));
        report_field("data_offset",   want.data_offset,        out_data_offset);
        report_field("data_size",     want.data_size,          out_data_size);
        report_field("fmt_too_short", 32'(want.fmt_too_short), 32'(out_fmt_too_short));
      end
      summaries_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. The payload changes only at a falling edge, and valid is held high,
  // with the payload steady, until the block takes the word. Back-to-back words
  // keep valid high throughout.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last,
                           output bit emit, output summary_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_file_byte = b;
    in_last_byte = last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    parse_byte(b, last, emit, s);
  endtask

  task automatic push_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) file_q.push_back(tag[8*i +: 8]);
  endtask

  task automatic push_le(input logic [31:0] v, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endtask

  // Builds one file into file_q. Nearly half the files are well formed with random content, so
  // the walk gets through the fmt body and the chunk list; the rest are corrupted,
  // cut short at a random point, left with a partial chunk header, or plain noise.
  task automatic make_wav_file();
    int unsigned kind;
    int unsigned fmt_len;
    int unsigned n_chunks;
    int unsigned cut;
    int unsigned cap;
    logic [15:0] afmt;
    logic [15:0] chans;
    logic [15:0] bps;
    logic [31:0] rate;
    logic [31:0] len;
    logic [31:0] name;
    logic [7:0]  fmt_body[16];
    file_q.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 20)) file_q.push_back(8'($urandom));
      return;
    end

    push_tag(TAG_RIFF);
    push_le($urandom, 4);
    push_tag(TAG_WAVE);
    push_tag(TAG_FMT);

    case ($urandom_range(9))
      0:       fmt_len = 0;
      1, 2:    fmt_len = $urandom_range(1, 15);
      3:       fmt_len = $urandom_range(17, 24);
      default: fmt_len = 16;
    endcase
    case ($urandom_range(4))
      0, 1, 2: afmt = AFMT_PCM;
      3:       afmt = 16'd3;
      default: afmt = 16'($urandom);
    endcase
    case ($urandom_range(4))
      0, 1:    chans = CHAN_MONO;
      2, 3:    chans = CHAN_STEREO;
      default: chans = 16'($urandom);
    endcase
    case ($urandom_range(4))
      0, 1:    bps = BITS_8;
      2, 3:    bps = BITS_16;
      default: bps = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0:       rate = 32'd8000;
      1:       rate = 32'd44100;
      2:       rate = 32'd48000;
      default: rate = $urandom;
    endcase
    // Byte rate and block alignment are not captured, so they are simply noise.
    for (int i = 0; i < 16; i++) fmt_body[i] = 8'($urandom);
    {fmt_body[1], fmt_body[0]}   = afmt;
    {fmt_body[3], fmt_body[2]}   = chans;
    {fmt_body[7], fmt_body[6], fmt_body[5], fmt_body[4]} = rate;
    {fmt_body[15], fmt_body[14]} = bps;

    push_le(fmt_len, 4);
    for (int unsigned i = 0; i < fmt_len; i++)
      file_q.push_back(i < 16 ? fmt_body[i] : 8'($urandom));

    n_chunks = $urandom_range(0, 3);
    for (int unsigned c = 0; c < n_chunks; c++) begin
      case ($urandom_range(5))
        0, 1, 2: name = TAG_DATA;
        3:       name = 32'h4C49_5354;                  // a LIST chunk
        4:       name = {TAG_DATA[31:8], 8'($urandom)}; // near miss on the data tag
        default: name = $urandom;
      endcase
      case ($urandom_range(9))
        0:       len = 32'hFFFF_FFFF;
        1:       len = $urandom;
        2:       len = 0;
        default: len = $urandom_range(1, 8);
      endcase
      push_tag(name);
      push_le(len, 4);
      // A huge chunk cannot be sent whole; the file then ends inside its body.
      cap = (len > 32'd12) ? $urandom_range(0, 6) : len;
      repeat (cap) file_q.push_back(8'($urandom));
      if (len > 32'd12) break;
    end

    if (kind < 27) begin
      // Flip one bit somewhere in the tags (or, harmlessly, in the RIFF size).
      cut = $urandom_range(0, 15);
      file_q[cut] = file_q[cut] ^ (8'd1 << $urandom_range(7));
    end else if (kind < 42) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else if (kind < 54) begin
      // A chunk header that the end of the file cuts off part-way.
      push_tag(TAG_DATA);
      push_le($urandom, 4);
      repeat ($urandom_range(1, 7)) void'(file_q.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    bit          emit;
    summary_t    s;
    int unsigned phase_start;
    int unsigned files_start;
    int unsigned wait_cycles;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_file_byte   = '0;
    in_last_byte   = 1'b0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bytes_sent        = 0;
    files_sent        = 0;
    summaries_checked = 0;
    mismatch_count    = 0;
    clear_parser();

    // Directed files, all of which end before the fmt tag is complete or break a tag,
    // so each summary is all zeros: a lone 00 byte, a lone FF byte, a RIFF tag with
    // its last letter wrong, and a header whose RIFF size is all ones and which stops
    // two letters into the fmt tag.
    dir_rows = '{
      '{8'h00, 1'b1, 1'b1},
      '{8'hFF, 1'b1, 1'b1},
      '{"R",   1'b0, 1'b0}, '{"I",   1'b0, 1'b0}, '{"F", 1'b0, 1'b0},
      '{"X",   1'b1, 1'b1},
      '{"R",   1'b0, 1'b0}, '{"I",   1'b0, 1'b0}, '{"F", 1'b0, 1'b0},
      '{"F",   1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0},
      '{"W",   1'b0, 1'b0}, '{"A",   1'b0, 1'b0}, '{"V", 1'b0, 1'b0},
      '{"E",   1'b0, 1'b0},
      '{"f",   1'b0, 1'b0},
      '{"m",   1'b1, 1'b1}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].fbyte, dir_rows[i].last, emit, s);
      if (emit) begin
        summaries_due.push_back(dir_rows[i].want_zero ? summary_t'('0) : s);
        files_sent++;
      end
    end

    // Random files in four pacing phases: free flowing, a slow sender, a slow
    // receiver, and both slow at once.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      phase_start = bytes_sent;
      files_start = files_sent;
      while (bytes_sent - phase_start < PHASE_BYTES || files_sent - files_start < PHASE_FILES) begin
        make_wav_file();
        foreach (file_q[i]) begin
          send_byte(file_q[i], (i == file_q.size() - 1), emit, s);
          if (emit) summaries_due.push_back(s);
        end
        files_sent++;
      end
    end

    @(negedge clk);
    in_valid     = 1'b0;
    in_last_byte = 1'b0;

    // Let the receiver drain, then allow a few cycles for any stray word.
    wait_cycles = 0;
    while (summaries_due.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (summaries_due.size() != 0) begin
      $display("%0d predicted summaries never arrived", summaries_due.size());
      mismatch_count += summaries_due.size();
    end

    $display("Parsed %0d bytes in %0d files; %0d summary words checked under four pacing mixes",
             bytes_sent, files_sent, summaries_checked);
    $display("Field mismatches and stray or missing words: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
